>>> rtl/tfo_pkg.sv
package tfo_pkg;

  // Default input component width (signed Q3.12).
  localparam int COMPONENT_BITS_DEF = 16;

  // Working width of exact intermediate vectors.
  localparam int WIDE_W = 64;

  // Unit vector components, signed Q1.14.
  localparam int UNIT_W   = 16;
  localparam int FRAC_W   = 14;
  localparam int UNIT_ONE = 16384;

  // Normalizer geometry: magnitudes are brought into [2^29, 2^30).
  localparam int NORM_TOP = 29;
  localparam int MAG_W    = NORM_TOP + 1;
  localparam int SQ_W     = 2 * MAG_W + 2;
  localparam int LEN_W    = MAG_W + 1;
  localparam int Q_W      = FRAC_W + 1;
  localparam int NUM_W    = MAG_W + FRAC_W + 1;

  // Shift steps: six right steps (32..1), then five left steps (16..1).
  localparam int SH_RIGHT = 6;
  localparam int SH_STEPS = 11;
  localparam int RT_STEPS = SQ_W / 2;

  // abs, max, shifts, square, sum, root, numerator, divide, sign
  localparam int NORM_LAT = 2 + SH_STEPS + 2 + RT_STEPS + 1 + Q_W + 1;
  localparam int ORTH_LAT = 4;
  localparam int HAND_LAT = 5;

  // Tangent is lifted by this many bits before the projection is removed.
  localparam int TP_SHIFT = 28;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic vld;
    logic deg;
  } ctl_t;

  function automatic int sh_amt(input int s);
    return (s < SH_RIGHT) ? (32 >> s) : (16 >> (s - SH_RIGHT));
  endfunction

endpackage

>>> rtl/tfo_norm.sv
module tfo_norm #(
  parameter int SB_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  tfo_pkg::wide_t      in_vec [3],
  input  logic [SB_W-1:0]     in_sb,
  output tfo_pkg::ctl_t       out_ctl,
  output tfo_pkg::unit_t      out_vec [3],
  output logic [SB_W-1:0]     out_sb
);

  localparam int LAT = tfo_pkg::NORM_LAT;
  localparam int WW  = tfo_pkg::WIDE_W;
  localparam int SQW = tfo_pkg::SQ_W;
  localparam int MW  = tfo_pkg::MAG_W;
  localparam int NW  = tfo_pkg::NUM_W;
  localparam int QW  = tfo_pkg::Q_W;
  localparam int LW  = tfo_pkg::LEN_W;
  localparam int RS  = tfo_pkg::RT_STEPS;
  localparam int SS  = tfo_pkg::SH_STEPS;

  logic [LAT-1:0]  vld_d;
  logic [SB_W+2:0] meta_d [LAT];

  logic [WW-1:0]   mag_a [3];
  logic [WW-1:0]   mx;
  logic [WW-1:0]   sh_m [SS+1];
  logic [WW-1:0]   sh_v [SS+1][3];
  logic [2*MW-1:0] sq [3];
  logic [MW-1:0]   sq_mag [3];
  logic [SQW-1:0]  rt_x [RS+1];
  logic [SQW-1:0]  rt_r [RS+1];
  logic [MW-1:0]   rt_mag [RS+1][3];
  logic [NW-1:0]   dv_rem [QW+1][3];
  logic [QW-1:0]   dv_q [QW+1][3];
  logic [LW-1:0]   dv_len [QW+1];
  logic [LW-1:0]   len;
  logic            zero;
  logic [2:0]      neg_in;
  logic [2:0]      neg_out;

  // Valid bits and sideband travel beside the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= '0;
    end else if (en) begin
      vld_d <= {vld_d[LAT-2:0], in_vld};
    end
  end

  assign neg_in = {in_vec[2][WW-1], in_vec[1][WW-1], in_vec[0][WW-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      meta_d[0] <= {in_sb, neg_in};
      for (int i = 1; i < LAT; i++) begin
        meta_d[i] <= meta_d[i-1];
      end
    end
  end

  // Magnitudes, then the largest one.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_a[i] <= in_vec[i][WW-1] ? WW'(-in_vec[i]) : WW'(in_vec[i]);
      end
    end
  end

  always_comb begin
    mx = mag_a[0];
    if (mag_a[1] > mx) begin
      mx = mag_a[1];
    end
    if (mag_a[2] > mx) begin
      mx = mag_a[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_m[0] <= mx;
      for (int i = 0; i < 3; i++) begin
        sh_v[0][i] <= mag_a[i];
      end
    end
  end

  // Normalizing shift, one binary step per stage.
  for (genvar s = 0; s < SS; s++) begin : g_sh
    localparam int K = tfo_pkg::sh_amt(s);
    if (s < tfo_pkg::SH_RIGHT) begin : g_right
      localparam logic [WW-1:0] LIM = WW'(1) << (tfo_pkg::NORM_TOP + K);
      always_ff @(posedge clk) begin
        if (en) begin
          if (sh_m[s] >= LIM) begin
            sh_m[s+1] <= sh_m[s] >> K;
            for (int i = 0; i < 3; i++) sh_v[s+1][i] <= sh_v[s][i] >> K;
          end else begin
            sh_m[s+1] <= sh_m[s];
            for (int i = 0; i < 3; i++) sh_v[s+1][i] <= sh_v[s][i];
          end
        end
      end
    end else begin : g_left
      localparam logic [WW-1:0] LIM = WW'(1) << (tfo_pkg::NORM_TOP + 1 - K);
      always_ff @(posedge clk) begin
        if (en) begin
          if (sh_m[s] < LIM) begin
            sh_m[s+1] <= sh_m[s] << K;
            for (int i = 0; i < 3; i++) sh_v[s+1][i] <= sh_v[s][i] << K;
          end else begin
            sh_m[s+1] <= sh_m[s];
            for (int i = 0; i < 3; i++) sh_v[s+1][i] <= sh_v[s][i];
          end
        end
      end
    end
  end

  // Squares, then their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i]     <= sh_v[SS][i][MW-1:0] * sh_v[SS][i][MW-1:0];
        sq_mag[i] <= sh_v[SS][i][MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_x[0]   <= SQW'(sq[0]) + SQW'(sq[1]) + SQW'(sq[2]);
      rt_r[0]   <= '0;
      rt_mag[0] <= sq_mag;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar j = 0; j < RS; j++) begin : g_rt
    localparam logic [SQW:0] BIT = (SQW+1)'(1) << (SQW - 2 - 2 * j);
    logic [SQW:0] trial;
    assign trial = {1'b0, rt_r[j]} + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rt_x[j]} >= trial) begin
          rt_x[j+1] <= rt_x[j] - trial[SQW-1:0];
          rt_r[j+1] <= (rt_r[j] >> 1) + BIT[SQW-1:0];
        end else begin
          rt_x[j+1] <= rt_x[j];
          rt_r[j+1] <= rt_r[j] >> 1;
        end
        rt_mag[j+1] <= rt_mag[j];
      end
    end
  end

  assign len = rt_r[RS][LW-1:0];

  // Rounded numerators, then restoring division one quotient bit per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      dv_len[0] <= len;
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= NW'({rt_mag[RS][i], tfo_pkg::FRAC_W'(0)}) + NW'(len >> 1);
        dv_q[0][i]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_dv
    localparam int B = QW - 1 - j;
    logic [NW-1:0] dvs;
    assign dvs = NW'(dv_len[j]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_len[j+1] <= dv_len[j];
        for (int i = 0; i < 3; i++) begin
          dv_q[j+1][i] <= dv_q[j][i];
          if (dv_rem[j][i] >= dvs) begin
            dv_rem[j+1][i]  <= dv_rem[j][i] - dvs;
            dv_q[j+1][i][B] <= 1'b1;
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
          end
        end
      end
    end
  end

  // Restore signs; a zero-length vector yields zeros.
  assign neg_out = meta_d[LAT-2][2:0];

  always_ff @(posedge clk) begin
    if (en) begin
      zero <= (dv_len[QW] == '0);
      for (int i = 0; i < 3; i++) begin
        if (dv_len[QW] == '0) begin
          out_vec[i] <= '0;
        end else if (neg_out[i]) begin
          out_vec[i] <= -tfo_pkg::UNIT_W'(dv_q[QW][i]);
        end else begin
          out_vec[i] <= tfo_pkg::UNIT_W'(dv_q[QW][i]);
        end
      end
    end
  end

  assign out_ctl = '{vld: vld_d[LAT-1], deg: zero};
  assign out_sb  = meta_d[LAT-1][SB_W+2:3];

endmodule

>>> rtl/tfo_orth.sv
module tfo_orth #(
  parameter int COMPONENT_BITS = tfo_pkg::COMPONENT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  tfo_pkg::ctl_t                    in_ctl,
  input  tfo_pkg::unit_t                   n_in [3],
  input  logic signed [COMPONENT_BITS-1:0] t_in [3],
  input  logic signed [COMPONENT_BITS-1:0] b_in [3],
  output tfo_pkg::ctl_t                    out_ctl,
  output tfo_pkg::wide_t                   tp [3],
  output tfo_pkg::unit_t                   n_out [3],
  output logic signed [COMPONENT_BITS-1:0] b_out [3]
);

  localparam int CB  = COMPONENT_BITS;
  localparam int P_W = CB + tfo_pkg::UNIT_W;
  localparam int D_W = P_W + 2;
  localparam int LAT = tfo_pkg::ORTH_LAT;

  tfo_pkg::ctl_t         ctl [LAT];
  tfo_pkg::unit_t        n_d [LAT][3];
  logic signed [CB-1:0]  t_d [2][3];
  logic signed [CB-1:0]  b_d [LAT][3];
  logic signed [P_W-1:0] p [3];
  logic signed [D_W-1:0] d;
  tfo_pkg::wide_t        nd [3];
  tfo_pkg::wide_t        ts [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) ctl[k] <= '0;
    end else if (en) begin
      ctl[0] <= in_ctl;
      for (int k = 1; k < LAT; k++) ctl[k] <= ctl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_d[0] <= n_in;
      t_d[0] <= t_in;
      b_d[0] <= b_in;
      t_d[1] <= t_d[0];
      for (int k = 1; k < LAT; k++) begin
        n_d[k] <= n_d[k-1];
        b_d[k] <= b_d[k-1];
      end
      // dot(n, T), then n * dot, then remove the projection
      for (int i = 0; i < 3; i++) p[i] <= n_in[i] * t_in[i];
      d <= D_W'(p[0]) + D_W'(p[1]) + D_W'(p[2]);
      for (int i = 0; i < 3; i++) begin
        nd[i] <= tfo_pkg::wide_t'(n_d[1][i]) * tfo_pkg::wide_t'(d);
        ts[i] <= tfo_pkg::wide_t'(t_d[1][i]) <<< tfo_pkg::TP_SHIFT;
      end
      for (int i = 0; i < 3; i++) tp[i] <= ts[i] - nd[i];
    end
  end

  assign out_ctl = ctl[LAT-1];
  assign n_out   = n_d[LAT-1];
  assign b_out   = b_d[LAT-1];

endmodule

>>> rtl/tfo_hand.sv
module tfo_hand #(
  parameter int COMPONENT_BITS = tfo_pkg::COMPONENT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  tfo_pkg::ctl_t                    in_ctl,
  input  tfo_pkg::unit_t                   n_in [3],
  input  tfo_pkg::unit_t                   t_in [3],
  input  logic signed [COMPONENT_BITS-1:0] b_in [3],
  output logic                             vld,
  output tfo_pkg::unit_t                   t_out [3],
  output tfo_pkg::unit_t                   b_out [3],
  output logic                             left,
  output logic                             deg
);

  localparam int CB   = COMPONENT_BITS;
  localparam int UW   = tfo_pkg::UNIT_W;
  localparam int FW   = tfo_pkg::FRAC_W;
  localparam int C_W  = 2 * UW;
  localparam int HP_W = C_W + CB;
  localparam int HS_W = HP_W + 2;
  localparam int BQ_W = C_W + 1 - FW;
  localparam int BN_W = BQ_W + 1;
  localparam int LAT  = tfo_pkg::HAND_LAT;
  localparam logic signed [BN_W-1:0] SAT_HI = BN_W'((1 << (UW - 1)) - 1);
  localparam logic signed [BN_W-1:0] SAT_LO = -BN_W'(1 << (UW - 1));

  tfo_pkg::ctl_t           ctl [LAT-1];
  tfo_pkg::unit_t          t_d [LAT-1][3];
  logic signed [CB-1:0]    b_d [2][3];
  logic signed [C_W-1:0]   xp [6];
  logic signed [C_W-1:0]   c [3];
  logic signed [HP_W-1:0]  hp [3];
  logic signed [BQ_W-1:0]  bq [3];
  logic signed [BQ_W-1:0]  bq_d [3];
  logic                    neg_h;
  logic signed [C_W:0]     cr [3];
  logic signed [BN_W-1:0]  bn [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT - 1; k++) ctl[k] <= '0;
      vld <= 1'b0;
    end else if (en) begin
      ctl[0] <= in_ctl;
      for (int k = 1; k < LAT - 1; k++) ctl[k] <= ctl[k-1];
      vld <= ctl[LAT-2].vld;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // round half toward +infinity: floor((c + 2^13) / 2^14)
      cr[i] = (C_W+1)'(c[i]) + (C_W+1)'(1 << (FW - 1));
      bn[i] = neg_h ? -BN_W'(bq_d[i]) : BN_W'(bq_d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_d[0] <= t_in;
      for (int k = 1; k < LAT - 1; k++) t_d[k] <= t_d[k-1];
      b_d[0] <= b_in;
      b_d[1] <= b_d[0];
      // cross(n, t): products, then differences
      xp[0] <= n_in[1] * t_in[2];
      xp[1] <= n_in[2] * t_in[1];
      xp[2] <= n_in[2] * t_in[0];
      xp[3] <= n_in[0] * t_in[2];
      xp[4] <= n_in[0] * t_in[1];
      xp[5] <= n_in[1] * t_in[0];
      for (int i = 0; i < 3; i++) c[i] <= xp[2*i] - xp[2*i+1];
      for (int i = 0; i < 3; i++) begin
        hp[i] <= c[i] * b_d[1][i];
        bq[i] <= cr[i][C_W:FW];
      end
      neg_h <= (HS_W'(hp[0]) + HS_W'(hp[1]) + HS_W'(hp[2])) < 0;
      bq_d  <= bq;
      // final word: flip by handedness, saturate, or zero when degenerate
      deg  <= ctl[LAT-2].deg;
      left <= neg_h & ~ctl[LAT-2].deg;
      for (int i = 0; i < 3; i++) begin
        if (ctl[LAT-2].deg) begin
          t_out[i] <= '0;
          b_out[i] <= '0;
        end else begin
          t_out[i] <= t_d[LAT-2][i];
          if (bn[i] > SAT_HI) begin
            b_out[i] <= SAT_HI[UW-1:0];
          end else if (bn[i] < SAT_LO) begin
            b_out[i] <= SAT_LO[UW-1:0];
          end else begin
            b_out[i] <= bn[i][UW-1:0];
          end
        end
      end
    end
  end

endmodule

>>> rtl/tangent_frame_orthogonalize_top.sv
// Channel  Direction  Handshake           Word
// -------  ---------  ------------------  -------------------------------------------
// input    in         in_valid/in_stall   normal, tangent, bitangent xyz (Q3.12)
// output   out        out_valid/out_stall unit tangent, bitangent xyz (Q1.14), flags
//
// One word enters per cycle unless the output is stalled; each word passes two 63-stage
// normalizers, 4 projection stages and 5 handedness/output stages.
// The normalizers set the depth: 31 square-root stages and 15 divide stages each.
// rst (synchronous) clears every valid bit; payload registers are not reset.
// A stalled output word freezes the whole pipeline; in_stall follows at once.
module tangent_frame_orthogonalize_top #(
  parameter int COMPONENT_BITS = tfo_pkg::COMPONENT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COMPONENT_BITS-1:0] normal_x,
  input  logic signed [COMPONENT_BITS-1:0] normal_y,
  input  logic signed [COMPONENT_BITS-1:0] normal_z,
  input  logic signed [COMPONENT_BITS-1:0] tangent_x,
  input  logic signed [COMPONENT_BITS-1:0] tangent_y,
  input  logic signed [COMPONENT_BITS-1:0] tangent_z,
  input  logic signed [COMPONENT_BITS-1:0] bitangent_x,
  input  logic signed [COMPONENT_BITS-1:0] bitangent_y,
  input  logic signed [COMPONENT_BITS-1:0] bitangent_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               out_tangent_x,
  output logic signed [15:0]               out_tangent_y,
  output logic signed [15:0]               out_tangent_z,
  output logic signed [15:0]               out_bitangent_x,
  output logic signed [15:0]               out_bitangent_y,
  output logic signed [15:0]               out_bitangent_z,
  output logic                             left_handed,
  output logic                             degenerate
);

  localparam int CB   = COMPONENT_BITS;
  localparam int UW   = tfo_pkg::UNIT_W;
  localparam int SA_W = 6 * CB;
  localparam int SB_W = 3 * UW + 3 * CB + 1;

  logic en;

  // Normal normalizer: tangent and bitangent ride along as sideband.
  tfo_pkg::wide_t   na_vec [3];
  logic [SA_W-1:0]  na_sb_in;
  logic [SA_W-1:0]  na_sb;
  tfo_pkg::ctl_t    na_ctl;
  tfo_pkg::unit_t   n_vec [3];
  logic signed [CB-1:0] t_raw [3];
  logic signed [CB-1:0] b_raw [3];

  // Projection removal.
  tfo_pkg::ctl_t    or_ctl;
  tfo_pkg::wide_t   tp [3];
  tfo_pkg::unit_t   or_n [3];
  logic signed [CB-1:0] or_b [3];

  // Tangent normalizer: unit normal, bitangent and normal flag ride along.
  logic [SB_W-1:0]  nb_sb_in;
  logic [SB_W-1:0]  nb_sb;
  tfo_pkg::ctl_t    nb_ctl;
  tfo_pkg::unit_t   t_vec [3];
  tfo_pkg::unit_t   hn [3];
  logic signed [CB-1:0] hb [3];
  tfo_pkg::ctl_t    hd_ctl;

  tfo_pkg::unit_t   t_res [3];
  tfo_pkg::unit_t   b_res [3];

  // Advance everything unless the output word is held.
  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  assign na_vec[0] = tfo_pkg::wide_t'(normal_x);
  assign na_vec[1] = tfo_pkg::wide_t'(normal_y);
  assign na_vec[2] = tfo_pkg::wide_t'(normal_z);
  assign na_sb_in  = {tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z};

  tfo_norm #(.SB_W(SA_W)) u_norm_n (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (in_valid),
    .in_vec (na_vec),
    .in_sb  (na_sb_in),
    .out_ctl(na_ctl),
    .out_vec(n_vec),
    .out_sb (na_sb)
  );

  assign t_raw[0] = na_sb[6*CB-1:5*CB];
  assign t_raw[1] = na_sb[5*CB-1:4*CB];
  assign t_raw[2] = na_sb[4*CB-1:3*CB];
  assign b_raw[0] = na_sb[3*CB-1:2*CB];
  assign b_raw[1] = na_sb[2*CB-1:CB];
  assign b_raw[2] = na_sb[CB-1:0];

  tfo_orth #(.COMPONENT_BITS(CB)) u_orth (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_ctl (na_ctl),
    .n_in   (n_vec),
    .t_in   (t_raw),
    .b_in   (b_raw),
    .out_ctl(or_ctl),
    .tp     (tp),
    .n_out  (or_n),
    .b_out  (or_b)
  );

  assign nb_sb_in = {or_n[0], or_n[1], or_n[2], or_b[0], or_b[1], or_b[2], or_ctl.deg};

  tfo_norm #(.SB_W(SB_W)) u_norm_t (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (or_ctl.vld),
    .in_vec (tp),
    .in_sb  (nb_sb_in),
    .out_ctl(nb_ctl),
    .out_vec(t_vec),
    .out_sb (nb_sb)
  );

  assign hn[0] = nb_sb[SB_W-1:SB_W-UW];
  assign hn[1] = nb_sb[SB_W-UW-1:SB_W-2*UW];
  assign hn[2] = nb_sb[SB_W-2*UW-1:SB_W-3*UW];
  assign hb[0] = nb_sb[3*CB:2*CB+1];
  assign hb[1] = nb_sb[2*CB:CB+1];
  assign hb[2] = nb_sb[CB:1];

  // Degenerate when either the normal or the projected tangent vanished.
  assign hd_ctl = '{vld: nb_ctl.vld, deg: nb_ctl.deg | nb_sb[0]};

  tfo_hand #(.COMPONENT_BITS(CB)) u_hand (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_ctl(hd_ctl),
    .n_in  (hn),
    .t_in  (t_vec),
    .b_in  (hb),
    .vld   (out_valid),
    .t_out (t_res),
    .b_out (b_res),
    .left  (left_handed),
    .deg   (degenerate)
  );

  assign out_tangent_x   = t_res[0];
  assign out_tangent_y   = t_res[1];
  assign out_tangent_z   = t_res[2];
  assign out_bitangent_x = b_res[0];
  assign out_bitangent_y = b_res[1];
  assign out_bitangent_z = b_res[2];

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> out_tangent_x == 0 && out_tangent_y == 0 &&
      out_tangent_z == 0 && out_bitangent_x == 0 && out_bitangent_y == 0 &&
      out_bitangent_z == 0 && !left_handed)
    else $error("degenerate word carries nonzero data");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_tangent_x <= 16384 && out_tangent_x >= -16384 &&
      out_tangent_y <= 16384 && out_tangent_y >= -16384 &&
      out_tangent_z <= 16384 && out_tangent_z >= -16384)
    else $error("tangent component beyond unit range");

  a_nonzero_tangent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> out_tangent_x != 0 || out_tangent_y != 0 ||
      out_tangent_z != 0)
    else $error("regular word with zero tangent");
`endif

endmodule

>>> dv/tb_tangent_frame_orthogonalize_top.sv
module tb_tangent_frame_orthogonalize_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Input vertex word: normal, tangent, bitangent in Q3.12.
  typedef struct {
    logic signed [15:0] nrm [3];
    logic signed [15:0] tan [3];
    logic signed [15:0] bit3 [3];
  } vertex_t;

  // Output frame word: unit tangent, rebuilt bitangent, flags.
  typedef struct {
    logic signed [15:0] tan [3];
    logic signed [15:0] bit3 [3];
    logic               left;
    logic               degen;
  } frame_t;

  localparam int PIPE_LAT  = 135;
  localparam int WATCHDOG  = 20000;
  localparam int N_RANDOM  = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [15:0] tangent_x = '0, tangent_y = '0, tangent_z = '0;
  logic signed [15:0] bitangent_x = '0, bitangent_y = '0, bitangent_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic signed [15:0] out_bitangent_x, out_bitangent_y, out_bitangent_z;
  logic left_handed, degenerate;

  vertex_t pending_q [$];
  frame_t  frame_q [$];
  int      n_errors = 0;
  int      n_frames = 0;
  int      n_degen = 0;
  int      n_left = 0;
  bit      hold_send = 1'b0;
  int      idle_cycles = 0;

  tangent_frame_orthogonalize_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .bitangent_x(bitangent_x), .bitangent_y(bitangent_y), .bitangent_z(bitangent_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tangent_x(out_tangent_x), .out_tangent_y(out_tangent_y),
    .out_tangent_z(out_tangent_z),
    .out_bitangent_x(out_bitangent_x), .out_bitangent_y(out_bitangent_y),
    .out_bitangent_z(out_bitangent_z),
    .left_handed(left_handed), .degenerate(degenerate)
  );

  always #2 clk = ~clk;

  // Append a word to the stimulus queue.
  task automatic queue_vertex(input vertex_t vx);
    pending_q = {pending_q, vx};
  endtask

  // Scale a vector so its largest magnitude sits in [2^29, 2^30), then make it
  // unit length in Q1.14 with round-half-away division by the integer root.
  function automatic bit unit_vec(input longint v [3], output longint o [3]);
    logic [63:0] mag [3];
    logic [63:0] peak, sq, len, q, rem, root, probe;
    bit neg [3];
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) return 1'b0;
    while (peak < (64'd1 << 29)) begin
      peak = peak << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    while (peak >= (64'd1 << 30)) begin
      peak = peak >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    // bitwise integer square root
    rem = sq;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    len = root;
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 64'd16384 + len / 2) / len;
      o[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // Round Q2.28 down to Q1.14, ties toward +infinity.
  function automatic longint to_q14(input longint v);
    if (v >= 0) return (v + 8192) >>> 14;
    return -((-v + 8191) >>> 14);
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic frame_t orthogonalize(input vertex_t vx);
    frame_t f;
    longint nv [3], tv [3], bv [3], n [3], tp [3], t [3], c [3];
    longint d, hs, b;
    f.left = 1'b0;
    f.degen = 1'b1;
    for (int i = 0; i < 3; i++) begin
      f.tan[i] = '0;
      f.bit3[i] = '0;
      nv[i] = vx.nrm[i];
      tv[i] = vx.tan[i];
      bv[i] = vx.bit3[i];
    end
    if (!unit_vec(nv, n)) return f;
    d = n[0] * tv[0] + n[1] * tv[1] + n[2] * tv[2];
    for (int i = 0; i < 3; i++) tp[i] = (tv[i] <<< 28) - n[i] * d;
    if (!unit_vec(tp, t)) return f;
    c[0] = n[1] * t[2] - n[2] * t[1];
    c[1] = n[2] * t[0] - n[0] * t[2];
    c[2] = n[0] * t[1] - n[1] * t[0];
    hs = c[0] * bv[0] + c[1] * bv[1] + c[2] * bv[2];
    f.left = hs < 0;
    f.degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      b = to_q14(c[i]);
      if (f.left) b = -b;
      f.tan[i] = clamp16(t[i]);
      f.bit3[i] = clamp16(b);
    end
    return f;
  endfunction

  function automatic vertex_t make_vertex(input int nx, ny, nz, tx, ty, tz,
                                          bx, by, bz);
    vertex_t vx;
    vx.nrm[0] = 16'(nx); vx.nrm[1] = 16'(ny); vx.nrm[2] = 16'(nz);
    vx.tan[0] = 16'(tx); vx.tan[1] = 16'(ty); vx.tan[2] = 16'(tz);
    vx.bit3[0] = 16'(bx); vx.bit3[1] = 16'(by); vx.bit3[2] = 16'(bz);
    return vx;
  endfunction

  // Random component: mostly full range, sometimes tiny or at an extreme.
  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 6))) - 16'sd3;
      2: return 16'sd0;
      default: return 16'($urandom());
    endcase
  endfunction

  // Driver: hold a stalled word; otherwise draw a gap after each accepted
  // word and raise the next one once the gap has run out.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (!(in_valid && in_stall)) begin
        if (in_valid) begin
          send_gap = $urandom_range(0, 3);
        end
        if (send_gap == 0 && !hold_send && pending_q.size() > 0) begin
          vertex_t vx;
          vx = pending_q.pop_front();
          frame_q = {frame_q, orthogonalize(vx)};
          normal_x <= vx.nrm[0];  normal_y <= vx.nrm[1];  normal_z <= vx.nrm[2];
          tangent_x <= vx.tan[0]; tangent_y <= vx.tan[1]; tangent_z <= vx.tan[2];
          bitangent_x <= vx.bit3[0]; bitangent_y <= vx.bit3[1];
          bitangent_z <= vx.bit3[2];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) begin
            send_gap--;
          end
        end
      end
    end
  end

  task automatic check_field(input string name, input longint exp_v, act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Monitor: compare each accepted frame against the oldest prediction, and
  // stall the output at random between frames.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (frame_q.size() == 0) begin
          $error("unexpected output word");
          n_errors++;
        end else begin
          frame_t f;
          f = frame_q.pop_front();
          check_field("out_tangent_x", f.tan[0], out_tangent_x);
          check_field("out_tangent_y", f.tan[1], out_tangent_y);
          check_field("out_tangent_z", f.tan[2], out_tangent_z);
          check_field("out_bitangent_x", f.bit3[0], out_bitangent_x);
          check_field("out_bitangent_y", f.bit3[1], out_bitangent_y);
          check_field("out_bitangent_z", f.bit3[2], out_bitangent_z);
          check_field("left_handed", f.left, left_handed);
          check_field("degenerate", f.degen, degenerate);
          n_frames++;
          n_degen += f.degen;
          n_left += f.left;
        end
        stall_left = $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    vertex_t vx;
    // Directed: axes, extremes, and each degenerate or boundary case.
    queue_vertex(make_vertex(4096, 0, 0, 0, 4096, 0, 0, 0, 4096));
    queue_vertex(make_vertex(4096, 0, 0, 0, 4096, 0, 0, 0, -4096));
    queue_vertex(make_vertex(0, 0, 0, 100, 200, 300, 1, 1, 1));    // zero normal
    queue_vertex(make_vertex(1, 2, 3, 2, 4, 6, 5, 5, 5));          // parallel T
    queue_vertex(make_vertex(0, 4096, 0, 0, 0, 0, 1, 0, 0));       // zero T
    queue_vertex(make_vertex(0, 0, 4096, 4096, 0, 0, 0, 0, 0));    // zero B
    queue_vertex(make_vertex(32767, 32767, 32767, -32768, 0, 32767,
                             -32768, -32768, -32768));
    queue_vertex(make_vertex(-32768, -32768, -32768, 32767, -32768, 0,
                             32767, 32767, 32767));
    queue_vertex(make_vertex(1, 0, 0, 0, 1, 0, 0, 0, 1));
    queue_vertex(make_vertex(-1, 0, 0, 0, 0, -1, 0, -1, 0));
    queue_vertex(make_vertex(1, 1, 1, -1, 1, 0, 1, -1, 0));
    queue_vertex(make_vertex(32767, 1, -1, 1, 32767, -32768, -1, 1, 32767));
    queue_vertex(make_vertex(-32768, 0, 0, 32767, 1, 0, 0, 1, 0));
    queue_vertex(make_vertex(3, -5, 7, -32768, 32767, -32768, 0, 0, -1));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Drain the directed set fully before the random part.
    hold_send = 1'b0;
    wait (pending_q.size() == 0 && frame_q.size() == 0);
    @(posedge clk);
    for (int k = 0; k < N_RANDOM; k++) begin
      for (int i = 0; i < 3; i++) begin
        vx.nrm[i] = rand_comp();
        vx.tan[i] = rand_comp();
        vx.bit3[i] = rand_comp();
      end
      // Now and then build a tangent that is the normal shifted right, near-parallel to it.
      if ($urandom_range(0, 19) == 0)
        for (int i = 0; i < 3; i++) vx.tan[i] = vx.nrm[i] >>> $urandom_range(0, 3);
      queue_vertex(vx);
      // Mid-run: stop sending until the pipeline has emptied.
      if (k == N_RANDOM / 2) begin
        wait (pending_q.size() == 0);
        hold_send = 1'b1;
        wait (frame_q.size() == 0);
        @(posedge clk);
        hold_send = 1'b0;
      end
    end
    wait (pending_q.size() == 0 && frame_q.size() == 0);
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (frame_q.size() != 0) begin
      $error("%0d expected words never arrived", frame_q.size());
      n_errors++;
    end
    $display("Checked %0d frames: %0d degenerate, %0d left-handed.",
             n_frames, n_degen, n_left);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
